FILE: rtl/nbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_pkg
// shared types, constants and helpers for the gravity step unit
// ----------------------------------------------------------------------------
package nbg_pkg;

  localparam int MAX_BODIES_DEF = 16;
  localparam int REPORT_LIMIT   = 16;
  localparam int DIVD_W         = 72;
  localparam int DIVS_W         = 34;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [23:0]        mass;
    logic [15:0]        radius;
  } body_t;

  localparam int BODY_W = $bits(body_t);

  typedef enum logic [1:0] {
    REG_COUNT    = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_HEIGHT   = 2'd2,
    REG_MIN_DIST = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_IRD, S_ICAP, S_JRD, S_JCAP, S_SQX, S_SQY, S_SUM, S_SQRT, S_CHK,
    S_DQ, S_DG, S_DUX, S_DUY, S_MX, S_AX, S_AY, S_WB, S_MRD, S_MCAP, S_DONE
  } state_t;

  typedef struct packed {
    logic              go;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh07fffffff) r = S32_MAX;
    else if (v < -34'sh080000000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/nbg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module nbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/nbg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nbg_div
  import nbg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              run_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVS_W:0]   rem_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] dvs_r;
  logic              done_r;
  logic [DIVS_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_r[DIVS_W-1:0], quo_r[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= req.dividend;
        dvs_r <= req.divisor;
      end else if (run_r) begin
        rem_r <= fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
        quo_r <= {quo_r[DIVD_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

FILE: rtl/nbody_gravity_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbody_gravity_step_unit
// direct-sum gravity step over a small table of bodies, Q16.16 fixed point
// ----------------------------------------------------------------------------
// usage:
//   command channel: an item transfers when start is high and busy is low.
//   a load item (in_op = 0) writes one body slot in that cycle, gives no
//   result and leaves busy low. a tick item (in_op = 1) with a nonzero
//   count raises busy from the next cycle until its last result is shown.
//   result channel: out_valid marks each result for exactly one cycle, one
//   per active body in slot order, out_last on the final one. the receiver
//   cannot stall, so results are never held back.
//   config channel: cfg_ready is always high; write only while idle.
// datapath:
//   each pair that exerts a pull uses one shared 32x32 multiplier, a
//   32-step square root, then four divisions on one shared restoring
//   divider. skipped pairs stop after the square root. the move pass
//   reads, moves and writes back each body in turn.
// reset:
//   all slots read as zero until written; registers take their defaults.
// ----------------------------------------------------------------------------
module nbody_gravity_step_unit
  import nbg_pkg::*;
#(
  parameter int MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [3:0]         in_slot,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic [23:0]        in_mass,
  input  logic [15:0]        in_radius,
  output logic               out_valid,
  output logic [3:0]         out_body,
  output logic signed [31:0] out_new_x,
  output logic signed [31:0] out_new_y,
  output logic signed [31:0] out_speed_x,
  output logic signed [31:0] out_speed_y,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int IW  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int LIM = (MAX_BODIES < REPORT_LIMIT) ? MAX_BODIES : REPORT_LIMIT;
  localparam int CW  = $clog2(LIM + 1);

  state_t state_r, state_nxt;

  logic [4:0]  count_r;
  logic [15:0] width_r, height_r, mind_r;

  logic [MAX_BODIES-1:0] valid_r;
  logic                  rd_ok_r;
  logic [CW-1:0]         n_r, i_r, j_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  body_t         ram_wdata, ram_rdata, rd_body;

  body_t              bi_r;
  logic [23:0]        mj_r;
  logic [15:0]        rj_r;
  logic [32:0]        ax_r, ay_r;
  logic               negx_r, negy_r, k_r;
  logic [31:0]        sx_r, sy_r;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_r, sq_acc_r;
  logic [63:0]        sq_v_r, sq_res_r, sq_bit_r;
  logic [4:0]         sq_cnt_r;
  logic [30:0]        g_r, ux_r, uy_r;
  logic [DIVS_W-1:0]  dval;
  logic               skip;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic                start_ok;
  logic signed [32:0]  dx, dy;
  logic [32:0]         adx, ady;
  logic [63:0]         sq_t;
  logic [31:0]         step_m;
  logic signed [31:0]  nx, ny;
  logic                hit_x, hit_y;
  logic [CW-1:0]       n_calc;

  assign start_ok  = start && !busy;
  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign rd_body   = rd_ok_r ? ram_rdata : '0;

  assign n_calc = (int'(count_r) > LIM) ? CW'(LIM) : CW'(count_r);

  assign dx  = {rd_body.x[31], rd_body.x} - {bi_r.x[31], bi_r.x};
  assign dy  = {rd_body.y[31], rd_body.y} - {bi_r.y[31], bi_r.y};
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);

  assign sq_t   = sq_res_r + sq_bit_r;
  assign dval   = k_r ? {sq_res_r[31:0], 2'b00} : {2'b00, sq_res_r[31:0]};
  assign skip   = (dval < DIVS_W'({17'({1'b0, bi_r.radius} + {1'b0, rj_r}), 16'h0}))
               || (dval <= DIVS_W'({mind_r, 16'h0}));
  assign step_m = prod_r[61:30];

  assign nx    = sat32(34'(rd_body.x) + 34'(rd_body.vx));
  assign ny    = sat32(34'(rd_body.y) + 34'(rd_body.vy));
  assign hit_x = ($signed({nx[31], nx}) >= $signed({1'b0, width_r, 16'h0})) || (nx <= 0);
  assign hit_y = ($signed({ny[31], ny}) >= $signed({1'b0, height_r, 16'h0})) || (ny <= 0);

  nbg_ram #(.WIDTH(BODY_W), .DEPTH(MAX_BODIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nbg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start_ok && in_op == OP_TICK && n_calc != '0) state_nxt = S_IRD;
      S_IRD:  state_nxt = S_ICAP;
      S_ICAP: state_nxt = S_JRD;
      S_JRD: begin
        if (j_r == n_r) state_nxt = S_WB;
        else if (j_r != i_r) state_nxt = S_JCAP;
      end
      S_JCAP: state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_SQRT;
      S_SQRT: if (sq_cnt_r == 5'd31) state_nxt = S_CHK;
      S_CHK:  state_nxt = skip ? S_JRD : S_DQ;
      S_DQ:   if (div_rsp.done) state_nxt = S_DG;
      S_DG:   if (div_rsp.done) state_nxt = S_DUX;
      S_DUX:  if (div_rsp.done) state_nxt = S_DUY;
      S_DUY:  if (div_rsp.done) state_nxt = S_MX;
      S_MX:   state_nxt = S_AX;
      S_AX:   state_nxt = S_AY;
      S_AY:   state_nxt = S_JRD;
      S_WB:   state_nxt = (i_r + 1'b1 == n_r) ? S_MRD : S_IRD;
      S_MRD:  state_nxt = S_MCAP;
      S_MCAP: state_nxt = (i_r + 1'b1 == n_r) ? S_DONE : S_MRD;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs to ram, multiplier and divider
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = IW'(i_r);
    ram_wdata       = bi_r;
    ram_raddr       = IW'(i_r);
    mul_a           = sx_r;
    mul_b           = sx_r;
    div_req.go      = 1'b0;
    div_req.divisor = dval;
    div_req.dividend = {16'h0, mj_r, 32'h0};
    unique case (state_r)
      S_IDLE: begin
        ram_we    = start_ok && in_op == OP_LOAD && int'(in_slot) < MAX_BODIES;
        ram_waddr = IW'(in_slot);
        ram_wdata = '{x: in_pos_x, y: in_pos_y, vx: in_vel_x, vy: in_vel_y,
                      mass: in_mass, radius: in_radius};
      end
      S_JRD: ram_raddr = IW'(j_r);
      S_SQY: begin
        mul_a = sy_r;
        mul_b = sy_r;
      end
      S_CHK: div_req.go = !skip;
      S_DQ: begin
        div_req.go       = div_rsp.done;
        div_req.dividend = {div_rsp.quo[55:0], 16'h0};
      end
      S_DG: begin
        div_req.go       = div_rsp.done;
        div_req.dividend = {9'h0, ax_r, 30'h0};
      end
      S_DUX: begin
        div_req.go       = div_rsp.done;
        div_req.dividend = {9'h0, ay_r, 30'h0};
      end
      S_MX: begin
        mul_a = {1'b0, g_r};
        mul_b = {1'b0, ux_r};
      end
      S_AX: begin
        mul_a = {1'b0, g_r};
        mul_b = {1'b0, uy_r};
      end
      S_WB: ram_we = 1'b1;
      S_MCAP: begin
        ram_we    = 1'b1;
        ram_wdata = rd_body;
        ram_wdata.x = nx;
        ram_wdata.y = ny;
        if (hit_x) ram_wdata.vx = sat32(-34'(rd_body.vx));
        else if (hit_y) ram_wdata.vy = sat32(-34'(rd_body.vy));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      width_r   <= 16'd800;
      height_r  <= 16'd600;
      mind_r    <= 16'd5;
      valid_r   <= '0;
      rd_ok_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_ok_r   <= valid_r[ram_raddr];
      out_valid <= (state_r == S_MCAP);
      if (ram_we) valid_r[ram_waddr] <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_COUNT:    count_r  <= cfg_data[4:0];
          REG_WIDTH:    width_r  <= cfg_data;
          REG_HEIGHT:   height_r <= cfg_data;
          REG_MIN_DIST: mind_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        n_r <= n_calc;
        i_r <= '0;
      end
      S_ICAP: begin
        bi_r <= rd_body;
        j_r  <= '0;
      end
      S_JRD: if (j_r == i_r) j_r <= j_r + 1'b1;
      S_JCAP: begin
        mj_r   <= rd_body.mass;
        rj_r   <= rd_body.radius;
        ax_r   <= adx;
        ay_r   <= ady;
        negx_r <= dx[32];
        negy_r <= dy[32];
        k_r    <= adx[32] || adx[31] || ady[32] || ady[31];
        if (adx[32] || adx[31] || ady[32] || ady[31]) begin
          sx_r <= 32'(adx >> 2);
          sy_r <= 32'(ady >> 2);
        end else begin
          sx_r <= adx[31:0];
          sy_r <= ady[31:0];
        end
      end
      S_SQY: sq_acc_r <= prod_r;
      S_SUM: begin
        sq_v_r   <= sq_acc_r + prod_r;
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
        sq_cnt_r <= '0;
      end
      S_SQRT: begin
        if (sq_v_r >= sq_t) begin
          sq_v_r   <= sq_v_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        sq_cnt_r <= sq_cnt_r + 1'b1;
      end
      S_CHK: if (skip) j_r <= j_r + 1'b1;
      S_DG: if (div_rsp.done) begin
        g_r <= (div_rsp.quo >= DIVD_W'(32'h7fffffff)) ? 31'h7fffffff : div_rsp.quo[30:0];
      end
      S_DUX: if (div_rsp.done) begin
        ux_r <= (div_rsp.quo > DIVD_W'(32'h40000000)) ? 31'h40000000 : div_rsp.quo[30:0];
      end
      S_DUY: if (div_rsp.done) begin
        uy_r <= (div_rsp.quo > DIVD_W'(32'h40000000)) ? 31'h40000000 : div_rsp.quo[30:0];
      end
      S_AX: begin
        bi_r.vx <= negx_r ? sat32(34'(bi_r.vx) - 34'({2'b00, step_m}))
                          : sat32(34'(bi_r.vx) + 34'({2'b00, step_m}));
      end
      S_AY: begin
        bi_r.vy <= negy_r ? sat32(34'(bi_r.vy) - 34'({2'b00, step_m}))
                          : sat32(34'(bi_r.vy) + 34'({2'b00, step_m}));
        j_r <= j_r + 1'b1;
      end
      S_WB: i_r <= (i_r + 1'b1 == n_r) ? '0 : i_r + 1'b1;
      S_MCAP: begin
        out_body    <= 4'(i_r);
        out_new_x   <= nx;
        out_new_y   <= ny;
        out_speed_x <= hit_x ? sat32(-34'(rd_body.vx)) : rd_body.vx;
        out_speed_y <= (!hit_x && hit_y) ? sat32(-34'(rd_body.vy)) : rd_body.vy;
        out_last    <= (i_r + 1'b1 == n_r);
        i_r         <= i_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/nbg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_checker
// port-level checks for the gravity step unit
// ----------------------------------------------------------------------------
module nbg_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_op,
  input logic out_valid,
  input logic out_last
);

  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a tick");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid && out_last)) else $error("tick ended without last");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_op) |=> (!busy && !out_valid)) else $error("load caused activity");

  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid) else $error("result after last");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && !busy)) else $error("activity after reset");

endmodule

bind nbody_gravity_step_unit nbg_checker u_nbg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_last  (out_last)
);
